@@ rtl/stu_pkg.sv @@
// Package: token kinds, error codes, lexer modes, queue entry type, keyword lookup.
`timescale 1ns / 1ps
`default_nettype none
package stu_pkg;

  localparam logic [5:0] K_EOF     = 6'd0;
  localparam logic [5:0] K_IDENT   = 6'd1;
  localparam logic [5:0] K_INTEGER = 6'd2;
  localparam logic [5:0] K_KW_INT  = 6'd3;
  localparam logic [5:0] K_KW_BOOL = 6'd4;
  localparam logic [5:0] K_KW_CHAR = 6'd5;
  localparam logic [5:0] K_KW_STR  = 6'd6;
  localparam logic [5:0] K_KW_IF   = 6'd7;
  localparam logic [5:0] K_KW_ELSE = 6'd8;
  localparam logic [5:0] K_KW_WHILE = 6'd9;
  localparam logic [5:0] K_KW_RETURN = 6'd10;
  localparam logic [5:0] K_KW_TRUE = 6'd11;
  localparam logic [5:0] K_KW_FALSE = 6'd12;
  localparam logic [5:0] K_KW_ECHO = 6'd13;
  localparam logic [5:0] K_KW_ENDL = 6'd14;
  localparam logic [5:0] K_PLUS    = 6'd15;
  localparam logic [5:0] K_MINUS   = 6'd16;
  localparam logic [5:0] K_STAR    = 6'd17;
  localparam logic [5:0] K_DIV     = 6'd18;
  localparam logic [5:0] K_LPAREN  = 6'd19;
  localparam logic [5:0] K_RPAREN  = 6'd20;
  localparam logic [5:0] K_CHARLIT = 6'd21;
  localparam logic [5:0] K_STRLIT  = 6'd22;
  localparam logic [5:0] K_LBRACE  = 6'd23;
  localparam logic [5:0] K_RBRACE  = 6'd24;
  localparam logic [5:0] K_NOTEQ   = 6'd25;
  localparam logic [5:0] K_NOT     = 6'd26;
  localparam logic [5:0] K_AND     = 6'd27;
  localparam logic [5:0] K_OR      = 6'd28;
  localparam logic [5:0] K_LT      = 6'd29;
  localparam logic [5:0] K_LE      = 6'd30;
  localparam logic [5:0] K_GT      = 6'd31;
  localparam logic [5:0] K_GE      = 6'd32;
  localparam logic [5:0] K_EQ      = 6'd33;
  localparam logic [5:0] K_ASSIGN  = 6'd34;
  localparam logic [5:0] K_SEMI    = 6'd35;
  localparam logic [5:0] K_UNKNOWN = 6'd36;
  localparam logic [5:0] K_ERROR   = 6'd37;

  localparam logic [2:0] E_NONE      = 3'd0;
  localparam logic [2:0] E_BAD_CHAR  = 3'd1;
  localparam logic [2:0] E_OPEN_STR  = 3'd2;
  localparam logic [2:0] E_LONE_AMP  = 3'd3;
  localparam logic [2:0] E_LONE_BAR  = 3'd4;

  localparam logic [30:0] ACC_MAX = 31'h7FFF_FFFF;
  localparam logic [15:0] POS_MAX = 16'hFFFF;

  typedef enum logic [3:0] {
    M_IDLE, M_INT, M_IDENT, M_SLASH, M_COMMENT, M_CHAR_OPEN, M_CHAR_CLOSE,
    M_STRING, M_BANG, M_AMP, M_BAR, M_LESS, M_GREATER, M_EQUAL, M_HALT
  } mode_t;

  // One queue entry: a main token plus an optional trailing simple token.
  typedef struct packed {
    logic [5:0]  kind1;
    logic [2:0]  err1;
    logic [15:0] line1;
    logic [15:0] col1;
    logic [30:0] num1;
    logic        has_text;
    logic        is_word;
    logic        second_v;
    logic [5:0]  kind2;
    logic [15:0] line2;
    logic [15:0] col2;
  } tok_cmd_t;

  // w holds the first six text bytes, first byte in the low bits.
  function automatic logic [5:0] kw_kind(input logic [47:0] w, input logic [6:0] len);
    logic [47:0] r;
    logic [5:0]  k;
    for (int i = 0; i < 6; i++) r[8*(5-i) +: 8] = w[8*i +: 8];
    k = K_IDENT;
    if (len == 7'd3 && r[47:24] == "int") k = K_KW_INT;
    if (len == 7'd4 && r[47:16] == "bool") k = K_KW_BOOL;
    if (len == 7'd4 && r[47:16] == "char") k = K_KW_CHAR;
    if (len == 7'd3 && r[47:24] == "str") k = K_KW_STR;
    if (len == 7'd6 && r[47:0] == "string") k = K_KW_STR;
    if (len == 7'd2 && r[47:32] == "if") k = K_KW_IF;
    if (len == 7'd4 && r[47:16] == "else") k = K_KW_ELSE;
    if (len == 7'd5 && r[47:8] == "while") k = K_KW_WHILE;
    if (len == 7'd6 && r[47:0] == "return") k = K_KW_RETURN;
    if (len == 7'd4 && r[47:16] == "true") k = K_KW_TRUE;
    if (len == 7'd5 && r[47:8] == "false") k = K_KW_FALSE;
    if (len == 7'd4 && r[47:16] == "echo") k = K_KW_ECHO;
    if (len == 7'd4 && r[47:16] == "endl") k = K_KW_ENDL;
    return k;
  endfunction

endpackage
`default_nettype wire

@@ rtl/stu_front.sv @@
// Lexer front end: mode machine, position counters, text store, token command push.
`timescale 1ns / 1ps
`default_nettype none
module stu_front #(
  parameter int TEXT_MAX = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic [7:0]             in_byte_req,
  input  wire logic                   in_end_of_input,
  input  wire logic                   in_fire,
  output logic                        push,
  output stu_pkg::tok_cmd_t           cmd,
  output logic [TEXT_MAX*8-1:0]       cmd_text,
  output logic [$clog2(TEXT_MAX)-1:0] cmd_len
);
  localparam int LW = $clog2(TEXT_MAX);
  localparam logic [LW-1:0] LEN_CAP = LW'(TEXT_MAX - 1);

  stu_pkg::mode_t mode_r, mode_nxt;
  logic [30:0] acc_r, acc_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [7:0] char_r, char_nxt;
  logic [15:0] line_r, line_nxt, col_r, col_nxt, tl_r, tl_nxt, tc_r, tc_nxt;
  logic [TEXT_MAX-1:0][7:0] store_r;
  logic wr_en;
  logic [LW-1:0] wr_idx;
  logic again, first_used;
  logic [7:0] b;
  logic eoi, dig, alpha, space;
  logic [34:0] acc10;
  logic [5:0] idle_kind;
  logic idle_emit;

  assign b = in_byte_req;
  assign eoi = in_end_of_input;
  assign dig = (b inside {["0":"9"]});
  assign alpha = (b inside {["a":"z"], ["A":"Z"], "_"});
  assign space = (b inside {8'd32, [8'd9:8'd13]});
  assign acc10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {31'b0, b[3:0]};

  assign cmd_text = store_r;
  assign cmd_len = len_r;

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    len_nxt = len_r;
    char_nxt = char_r;
    line_nxt = line_r;
    col_nxt = col_r;
    tl_nxt = tl_r;
    tc_nxt = tc_r;
    wr_en = 1'b0;
    wr_idx = len_r;
    cmd = '0;
    push = 1'b0;
    again = 1'b0;
    idle_emit = 1'b0;
    idle_kind = stu_pkg::K_EOF;
    if (in_fire && mode_r != stu_pkg::M_HALT) begin
      case (mode_r)
        stu_pkg::M_INT: begin
          if (!eoi && dig) begin
            acc_nxt = (acc10 > {4'b0, stu_pkg::ACC_MAX}) ? stu_pkg::ACC_MAX : acc10[30:0];
          end else begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_INTEGER;
            cmd.num1 = acc_r;
            again = 1'b1;
          end
        end
        stu_pkg::M_IDENT: begin
          if (!eoi && (alpha || dig)) begin
            if (len_r < LEN_CAP) begin
              wr_en = 1'b1;
              len_nxt = len_r + 1'b1;
            end
          end else begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_IDENT;
            cmd.has_text = 1'b1;
            cmd.is_word = 1'b1;
            again = 1'b1;
          end
        end
        stu_pkg::M_SLASH: begin
          if (!eoi && b == "/") mode_nxt = stu_pkg::M_COMMENT;
          else begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_DIV;
            again = 1'b1;
          end
        end
        stu_pkg::M_COMMENT: begin
          if (eoi || b == 8'd10) again = 1'b1;
        end
        stu_pkg::M_CHAR_OPEN: begin
          if (eoi) begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_ERROR;
            cmd.err1 = stu_pkg::E_BAD_CHAR;
            mode_nxt = stu_pkg::M_HALT;
          end else begin
            char_nxt = b;
            mode_nxt = stu_pkg::M_CHAR_CLOSE;
          end
        end
        stu_pkg::M_CHAR_CLOSE: begin
          push = 1'b1;
          if (!eoi && b == 8'd39) begin
            cmd.kind1 = stu_pkg::K_CHARLIT;
            cmd.num1 = {23'b0, char_r};
            mode_nxt = stu_pkg::M_IDLE;
          end else begin
            cmd.kind1 = stu_pkg::K_ERROR;
            cmd.err1 = stu_pkg::E_BAD_CHAR;
            mode_nxt = stu_pkg::M_HALT;
          end
        end
        stu_pkg::M_STRING: begin
          if (eoi) begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_ERROR;
            cmd.err1 = stu_pkg::E_OPEN_STR;
            mode_nxt = stu_pkg::M_HALT;
          end else if (b == 8'd34) begin
            push = 1'b1;
            cmd.kind1 = stu_pkg::K_STRLIT;
            cmd.has_text = 1'b1;
            mode_nxt = stu_pkg::M_IDLE;
          end else if (len_r < LEN_CAP) begin
            wr_en = 1'b1;
            len_nxt = len_r + 1'b1;
          end
        end
        stu_pkg::M_AMP, stu_pkg::M_BAR: begin
          push = 1'b1;
          if (!eoi && b == ((mode_r == stu_pkg::M_AMP) ? "&" : "|")) begin
            cmd.kind1 = (mode_r == stu_pkg::M_AMP) ? stu_pkg::K_AND : stu_pkg::K_OR;
            mode_nxt = stu_pkg::M_IDLE;
          end else begin
            cmd.kind1 = stu_pkg::K_ERROR;
            cmd.err1 = (mode_r == stu_pkg::M_AMP) ? stu_pkg::E_LONE_AMP : stu_pkg::E_LONE_BAR;
            mode_nxt = stu_pkg::M_HALT;
          end
        end
        stu_pkg::M_BANG, stu_pkg::M_LESS, stu_pkg::M_GREATER, stu_pkg::M_EQUAL: begin
          push = 1'b1;
          if (!eoi && b == "=") begin
            case (mode_r)
              stu_pkg::M_BANG:    cmd.kind1 = stu_pkg::K_NOTEQ;
              stu_pkg::M_LESS:    cmd.kind1 = stu_pkg::K_LE;
              stu_pkg::M_GREATER: cmd.kind1 = stu_pkg::K_GE;
              default:            cmd.kind1 = stu_pkg::K_EQ;
            endcase
            mode_nxt = stu_pkg::M_IDLE;
          end else begin
            case (mode_r)
              stu_pkg::M_BANG:    cmd.kind1 = stu_pkg::K_NOT;
              stu_pkg::M_LESS:    cmd.kind1 = stu_pkg::K_LT;
              stu_pkg::M_GREATER: cmd.kind1 = stu_pkg::K_GT;
              default:            cmd.kind1 = stu_pkg::K_ASSIGN;
            endcase
            again = 1'b1;
          end
        end
        default: again = 1'b1;
      endcase

      // pending tokens start at the saved position, errors at the current one
      if (cmd.kind1 == stu_pkg::K_ERROR) begin
        cmd.line1 = line_r;
        cmd.col1 = col_r;
      end else begin
        cmd.line1 = tl_r;
        cmd.col1 = tc_r;
      end
      first_used = push;

      if (again) begin
        tl_nxt = line_r;
        tc_nxt = col_r;
        mode_nxt = stu_pkg::M_IDLE;
        if (eoi) begin
          idle_emit = 1'b1;
          idle_kind = stu_pkg::K_EOF;
        end else if (space) begin
          mode_nxt = stu_pkg::M_IDLE;
        end else if (dig) begin
          acc_nxt = {27'b0, b[3:0]};
          mode_nxt = stu_pkg::M_INT;
        end else if (alpha) begin
          wr_en = 1'b1;
          wr_idx = '0;
          len_nxt = LW'(1);
          mode_nxt = stu_pkg::M_IDENT;
        end else begin
          case (b)
            "+": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_PLUS; end
            "-": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_MINUS; end
            "*": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_STAR; end
            "(": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_LPAREN; end
            ")": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_RPAREN; end
            "{": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_LBRACE; end
            "}": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_RBRACE; end
            ";": begin idle_emit = 1'b1; idle_kind = stu_pkg::K_SEMI; end
            "/": mode_nxt = stu_pkg::M_SLASH;
            8'd39: mode_nxt = stu_pkg::M_CHAR_OPEN;
            8'd34: begin len_nxt = '0; mode_nxt = stu_pkg::M_STRING; end
            "!": mode_nxt = stu_pkg::M_BANG;
            "&": mode_nxt = stu_pkg::M_AMP;
            "|": mode_nxt = stu_pkg::M_BAR;
            "<": mode_nxt = stu_pkg::M_LESS;
            ">": mode_nxt = stu_pkg::M_GREATER;
            "=": mode_nxt = stu_pkg::M_EQUAL;
            default: begin idle_emit = 1'b1; idle_kind = stu_pkg::K_UNKNOWN; end
          endcase
        end
        if (idle_emit) begin
          push = 1'b1;
          if (first_used) begin
            cmd.second_v = 1'b1;
            cmd.kind2 = idle_kind;
            cmd.line2 = line_r;
            cmd.col2 = col_r;
          end else begin
            cmd.kind1 = idle_kind;
            cmd.line1 = line_r;
            cmd.col1 = col_r;
          end
        end
      end

      if (mode_nxt != stu_pkg::M_HALT && !eoi) begin
        if (b == 8'd10) begin
          if (line_r != stu_pkg::POS_MAX) line_nxt = line_r + 16'd1;
          col_nxt = 16'd1;
        end else if (col_r != stu_pkg::POS_MAX) begin
          col_nxt = col_r + 16'd1;
        end
      end
    end else begin
      first_used = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= stu_pkg::M_IDLE;
      acc_r <= '0;
      len_r <= '0;
      char_r <= '0;
      line_r <= 16'd1;
      col_r <= 16'd1;
      tl_r <= 16'd1;
      tc_r <= 16'd1;
    end else begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
      len_r <= len_nxt;
      char_r <= char_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      tl_r <= tl_nxt;
      tc_r <= tc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_r[wr_idx] <= b;
  end

endmodule
`default_nettype wire

@@ rtl/stu_fifo.sv @@
// Small token command queue between lexer front end and output back end.
`timescale 1ns / 1ps
`default_nettype none
module stu_fifo #(
  parameter int W = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic              not_empty,
  output logic [W-1:0]      head
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW + 1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/stu_back.sv @@
// Output back end: expands token commands into result transfers, text in 8-byte words.
`timescale 1ns / 1ps
`default_nettype none
module stu_back #(
  parameter int TEXT_MAX = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  input  wire stu_pkg::tok_cmd_t             q_cmd,
  input  wire logic [TEXT_MAX*8-1:0]         q_text,
  input  wire logic [$clog2(TEXT_MAX)-1:0]   q_len,
  output logic                               q_pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [5:0]                         out_kind,
  output logic [2:0]                         out_error_code,
  output logic [15:0]                        out_start_line,
  output logic [15:0]                        out_start_column,
  output logic [30:0]                        out_number,
  output logic [63:0]                        out_text_word,
  output logic [3:0]                         out_text_bytes,
  output logic                               out_last
);
  localparam int LW = $clog2(TEXT_MAX);
  // remaining-byte count must also hold the word size for short text limits
  localparam int RW = (LW + 1 > 4) ? LW + 1 : 4;
  localparam int NW = (TEXT_MAX + 7) / 8;
  localparam int WIW = (NW > 1) ? $clog2(NW) : 1;

  stu_pkg::tok_cmd_t cur_r;
  logic [TEXT_MAX*8-1:0] text_r;
  logic [LW-1:0] len_r;
  logic [WIW-1:0] wi_r;
  logic sec_r, cur_v_r;
  logic out_valid_r;

  logic emit, done, lastw;
  logic [RW-1:0] rem;
  logic [NW*64-1:0] pad;
  logic [63:0] chunk, masked;
  logic [3:0] nb;
  logic [47:0] window;
  logic [5:0] word_kind;

  assign out_valid = out_valid_r;
  assign pad = (NW * 64)'(text_r);
  assign chunk = pad[64 * wi_r +: 64];
  assign rem = RW'(len_r) - RW'({wi_r, 3'b000});
  assign lastw = (rem <= RW'(8));
  assign nb = (rem >= RW'(8)) ? 4'd8 : 4'(rem);

  always_comb begin
    for (int j = 0; j < 8; j++) masked[8*j +: 8] = (4'(j) < nb) ? chunk[8*j +: 8] : 8'd0;
  end

  for (genvar i = 0; i < 6; i++) begin : g_win
    if (i < TEXT_MAX) begin : g_on
      assign window[8*i +: 8] = text_r[8*i +: 8];
    end else begin : g_off
      assign window[8*i +: 8] = 8'd0;
    end
  end

  assign word_kind = stu_pkg::kw_kind(window, 7'(len_r));

  assign emit = cur_v_r && (!out_valid_r || out_ready);
  assign done = emit && (sec_r || ((!cur_r.has_text || lastw) && !cur_r.second_v));
  assign q_pop = q_valid && (!cur_v_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_valid_r <= 1'b0;
      sec_r <= 1'b0;
      wi_r <= '0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (q_pop) begin
        cur_v_r <= 1'b1;
        sec_r <= 1'b0;
        wi_r <= '0;
      end else if (done) begin
        cur_v_r <= 1'b0;
      end else if (emit) begin
        if (cur_r.has_text && !lastw) wi_r <= wi_r + 1'b1;
        else sec_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
      text_r <= q_text;
      len_r <= q_len;
    end
    if (emit) begin
      if (sec_r) begin
        out_kind <= cur_r.kind2;
        out_error_code <= stu_pkg::E_NONE;
        out_start_line <= cur_r.line2;
        out_start_column <= cur_r.col2;
        out_number <= '0;
        out_text_word <= '0;
        out_text_bytes <= '0;
        out_last <= 1'b1;
      end else begin
        out_kind <= cur_r.is_word ? word_kind : cur_r.kind1;
        out_error_code <= cur_r.err1;
        out_start_line <= cur_r.line1;
        out_start_column <= cur_r.col1;
        out_number <= cur_r.num1;
        out_text_word <= cur_r.has_text ? masked : 64'd0;
        out_text_bytes <= cur_r.has_text ? nb : 4'd0;
        out_last <= !cur_r.has_text || lastw;
      end
    end
  end

  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind == stu_pkg::K_ERROR |-> out_last)
    else $error("error token spans several transfers");
  a_code_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_error_code != stu_pkg::E_NONE |-> out_kind == stu_pkg::K_ERROR)
    else $error("error code on a non-error token");
  a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_text_bytes <= 4'd8)
    else $error("text byte count above eight");
  a_sec_cur: assert property (@(posedge clk) disable iff (!rst_n)
    cur_v_r && sec_r |-> cur_r.second_v)
    else $error("trailing token phase without a trailing token");

endmodule
`default_nettype wire

@@ rtl/source_tokenizer_unit.sv @@
// Top level of the streaming source tokenizer.
// Input channel: one source byte per transfer (in_byte_req), or an end marker
//   (in_end_of_input = 1, byte ignored), with in_valid / in_ready.
// Output channel: one result item per transfer, out_valid / out_ready. A token
//   is one item, or for identifiers, keywords and strings one item per 8 text
//   bytes, out_last set on its final item. Errors give one kind-37 item, then
//   every further byte is taken and dropped until reset.
// Throughput: one byte per cycle into the lexer front end; the back end gives
//   one result item per cycle while out_ready holds. The 4-entry token queue
//   between them decouples the two; in_ready drops only while that queue is
//   full, e.g. while long text tokens drain at one 8-byte word per cycle.
// Output path: with the back end idle, a token's first item goes from the transfer
//   that completes it through the queue write at that edge, the back-end command
//   register and the output register; items queued ahead of it go out first.
// Reset (rst_n low, synchronous): lexer idle, position line 1 column 1, queue
//   and output register empty. No clearing pass; text storage is only read
//   within the token that wrote it.
// Receiver stall: the output register holds its item; the back end then
//   stops, the queue fills, and only then is the input throttled.
`timescale 1ns / 1ps
`default_nettype none
module source_tokenizer_unit #(
  parameter int TEXT_MAX = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [7:0]  in_byte_req,
  input  wire logic        in_end_of_input,
  input  wire logic        in_valid,
  output logic             in_ready,
  output logic [5:0]       out_kind,
  output logic [2:0]       out_error_code,
  output logic [15:0]      out_start_line,
  output logic [15:0]      out_start_column,
  output logic [30:0]      out_number,
  output logic [63:0]      out_text_word,
  output logic [3:0]       out_text_bytes,
  output logic             out_last,
  output logic             out_valid,
  input  wire logic        out_ready
);
  localparam int LW = $clog2(TEXT_MAX);
  localparam int QW = $bits(stu_pkg::tok_cmd_t) + TEXT_MAX * 8 + LW;

  logic push, full, q_valid, q_pop, in_fire;
  stu_pkg::tok_cmd_t f_cmd, q_cmd;
  logic [TEXT_MAX*8-1:0] f_text, q_text;
  logic [LW-1:0] f_len, q_len;
  logic [QW-1:0] q_head;

  assign in_ready = !full;
  assign in_fire = in_valid && in_ready;

  // front end: lexes one byte per transfer, pushes finished tokens
  stu_front #(.TEXT_MAX(TEXT_MAX)) u_front (
    .clk, .rst_n, .in_byte_req, .in_end_of_input, .in_fire,
    .push, .cmd(f_cmd), .cmd_text(f_text), .cmd_len(f_len)
  );

  stu_fifo #(.W(QW), .DEPTH(4)) u_fifo (
    .clk, .rst_n, .push, .push_data({f_cmd, f_text, f_len}), .full,
    .pop(q_pop), .not_empty(q_valid), .head(q_head)
  );

  assign {q_cmd, q_text, q_len} = q_head;

  // back end: turns commands into result transfers
  stu_back #(.TEXT_MAX(TEXT_MAX)) u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .q_text, .q_len, .q_pop,
    .out_valid, .out_ready, .out_kind, .out_error_code, .out_start_line,
    .out_start_column, .out_number, .out_text_word, .out_text_bytes, .out_last
  );

endmodule
`default_nettype wire

@@ verif/tokenizer_checker.sv @@
// Tokenizer checker: watches both channels, predicts result items, compares them.
`timescale 1ns / 1ps
module tokenizer_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_byte_req,
  input  logic        in_end_of_input,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [5:0]  out_kind,
  input  logic [2:0]  out_error_code,
  input  logic [15:0] out_start_line,
  input  logic [15:0] out_start_column,
  input  logic [30:0] out_number,
  input  logic [63:0] out_text_word,
  input  logic [3:0]  out_text_bytes,
  input  logic        out_last,
  input  logic        out_valid,
  input  logic        out_ready,
  output int          fail_count,
  output int          outstanding
);

  localparam int KEEP_MAX = 31;

  typedef struct {
    logic [5:0]  kind;
    logic [2:0]  err;
    logic [15:0] ln;
    logic [15:0] col;
    logic [30:0] num;
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        lst;
  } token_item_t;

  token_item_t token_items_due[$];

  // lexer shadow state
  stu_pkg::mode_t lex_mode;
  logic [30:0] digits_acc;
  logic [7:0]  kept_text[KEEP_MAX];
  int          kept_len;
  logic [7:0]  quoted_byte;
  logic [15:0] cur_line, cur_col, tok_line, tok_col;

  initial fail_count = 0;
  assign outstanding = token_items_due.size();

  function automatic bit is_num(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit text_is(string kw);
    if (kw.len() != kept_len) return 0;
    for (int i = 0; i < kept_len; i++)
      if (kw[i] != kept_text[i]) return 0;
    return 1;
  endfunction

  function automatic logic [5:0] word_class();
    if (text_is("int")) return stu_pkg::K_KW_INT;
    if (text_is("bool")) return stu_pkg::K_KW_BOOL;
    if (text_is("char")) return stu_pkg::K_KW_CHAR;
    if (text_is("str") || text_is("string")) return stu_pkg::K_KW_STR;
    if (text_is("if")) return stu_pkg::K_KW_IF;
    if (text_is("else")) return stu_pkg::K_KW_ELSE;
    if (text_is("while")) return stu_pkg::K_KW_WHILE;
    if (text_is("return")) return stu_pkg::K_KW_RETURN;
    if (text_is("true")) return stu_pkg::K_KW_TRUE;
    if (text_is("false")) return stu_pkg::K_KW_FALSE;
    if (text_is("echo")) return stu_pkg::K_KW_ECHO;
    if (text_is("endl")) return stu_pkg::K_KW_ENDL;
    return stu_pkg::K_IDENT;
  endfunction

  task automatic push_item(logic [5:0] kind, logic [2:0] err, logic [15:0] ln,
                           logic [15:0] col, logic [30:0] num, logic [63:0] word,
                           logic [3:0] nbytes, logic lst);
    token_item_t t;
    t.kind = kind; t.err = err; t.ln = ln; t.col = col; t.num = num;
    t.word = word; t.nbytes = nbytes; t.lst = lst;
    token_items_due.push_back(t);
  endtask

  task automatic push_plain(logic [5:0] kind, logic [30:0] num);
    push_item(kind, stu_pkg::E_NONE, tok_line, tok_col, num, '0, '0, 1'b1);
  endtask

  // text goes out 8 bytes per item; an empty body is still one item
  task automatic push_text(logic [5:0] kind);
    int pos, n;
    logic [63:0] w;
    pos = 0;
    if (kept_len == 0) begin
      push_plain(kind, '0);
      return;
    end
    while (pos < kept_len) begin
      n = (kept_len - pos > 8) ? 8 : kept_len - pos;
      w = '0;
      for (int i = 0; i < n; i++) w[8*i +: 8] = kept_text[pos + i];
      pos += n;
      push_item(kind, stu_pkg::E_NONE, tok_line, tok_col, '0, w, n[3:0], pos >= kept_len);
    end
  endtask

  task automatic keep_byte(logic [7:0] b);
    if (kept_len < KEEP_MAX) begin
      kept_text[kept_len] = b;
      kept_len++;
    end
  endtask

  task automatic flag_error(logic [2:0] code);
    push_item(stu_pkg::K_ERROR, code, cur_line, cur_col, '0, '0, '0, 1'b1);
    lex_mode = stu_pkg::M_HALT;
  endtask

  task automatic begin_token(logic [7:0] b, logic eoi);
    tok_line = cur_line;
    tok_col = cur_col;
    lex_mode = stu_pkg::M_IDLE;
    if (eoi) begin
      push_plain(stu_pkg::K_EOF, '0);
      return;
    end
    if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
    if (is_num(b)) begin
      digits_acc = 31'(b - "0");
      lex_mode = stu_pkg::M_INT;
      return;
    end
    if (is_letter(b)) begin
      kept_len = 0;
      keep_byte(b);
      lex_mode = stu_pkg::M_IDENT;
      return;
    end
    case (b)
      "+": push_plain(stu_pkg::K_PLUS, '0);
      "-": push_plain(stu_pkg::K_MINUS, '0);
      "*": push_plain(stu_pkg::K_STAR, '0);
      "(": push_plain(stu_pkg::K_LPAREN, '0);
      ")": push_plain(stu_pkg::K_RPAREN, '0);
      "{": push_plain(stu_pkg::K_LBRACE, '0);
      "}": push_plain(stu_pkg::K_RBRACE, '0);
      ";": push_plain(stu_pkg::K_SEMI, '0);
      "/": lex_mode = stu_pkg::M_SLASH;
      "'": lex_mode = stu_pkg::M_CHAR_OPEN;
      "\"": begin
        kept_len = 0;
        lex_mode = stu_pkg::M_STRING;
      end
      "!": lex_mode = stu_pkg::M_BANG;
      "&": lex_mode = stu_pkg::M_AMP;
      "|": lex_mode = stu_pkg::M_BAR;
      "<": lex_mode = stu_pkg::M_LESS;
      ">": lex_mode = stu_pkg::M_GREATER;
      "=": lex_mode = stu_pkg::M_EQUAL;
      default: push_plain(stu_pkg::K_UNKNOWN, '0);
    endcase
  endtask

  task automatic lex_transfer(logic [7:0] b, logic eoi);
    bit relex;
    logic [5:0] pair_kind, single_kind;
    logic [63:0] wide;
    relex = 0;
    pair_kind = '0;
    single_kind = '0;
    if (lex_mode == stu_pkg::M_HALT) return;
    case (lex_mode)
      stu_pkg::M_INT: begin
        if (!eoi && is_num(b)) begin
          wide = 64'(digits_acc) * 10 + 64'(b - "0");
          digits_acc = (wide > 64'(stu_pkg::ACC_MAX)) ? stu_pkg::ACC_MAX : wide[30:0];
        end else begin
          push_plain(stu_pkg::K_INTEGER, digits_acc);
          relex = 1;
        end
      end
      stu_pkg::M_IDENT: begin
        if (!eoi && (is_letter(b) || is_num(b))) keep_byte(b);
        else begin
          push_text(word_class());
          relex = 1;
        end
      end
      stu_pkg::M_SLASH: begin
        if (!eoi && b == "/") lex_mode = stu_pkg::M_COMMENT;
        else begin
          push_plain(stu_pkg::K_DIV, '0);
          relex = 1;
        end
      end
      stu_pkg::M_COMMENT: if (eoi || b == 8'h0A) relex = 1;
      stu_pkg::M_CHAR_OPEN: begin
        if (eoi) flag_error(stu_pkg::E_BAD_CHAR);
        else begin
          quoted_byte = b;
          lex_mode = stu_pkg::M_CHAR_CLOSE;
        end
      end
      stu_pkg::M_CHAR_CLOSE: begin
        if (!eoi && b == "'") begin
          push_plain(stu_pkg::K_CHARLIT, 31'(quoted_byte));
          lex_mode = stu_pkg::M_IDLE;
        end else flag_error(stu_pkg::E_BAD_CHAR);
      end
      stu_pkg::M_STRING: begin
        if (eoi) flag_error(stu_pkg::E_OPEN_STR);
        else if (b == "\"") begin
          push_text(stu_pkg::K_STRLIT);
          lex_mode = stu_pkg::M_IDLE;
        end else keep_byte(b);
      end
      stu_pkg::M_AMP: begin
        if (!eoi && b == "&") begin
          push_plain(stu_pkg::K_AND, '0);
          lex_mode = stu_pkg::M_IDLE;
        end else flag_error(stu_pkg::E_LONE_AMP);
      end
      stu_pkg::M_BAR: begin
        if (!eoi && b == "|") begin
          push_plain(stu_pkg::K_OR, '0);
          lex_mode = stu_pkg::M_IDLE;
        end else flag_error(stu_pkg::E_LONE_BAR);
      end
      stu_pkg::M_BANG: begin pair_kind = stu_pkg::K_NOTEQ; single_kind = stu_pkg::K_NOT; end
      stu_pkg::M_LESS: begin pair_kind = stu_pkg::K_LE; single_kind = stu_pkg::K_LT; end
      stu_pkg::M_GREATER: begin pair_kind = stu_pkg::K_GE; single_kind = stu_pkg::K_GT; end
      stu_pkg::M_EQUAL: begin pair_kind = stu_pkg::K_EQ; single_kind = stu_pkg::K_ASSIGN; end
      default: relex = 1;
    endcase
    if (pair_kind != '0) begin
      if (!eoi && b == "=") begin
        push_plain(pair_kind, '0);
        lex_mode = stu_pkg::M_IDLE;
      end else begin
        push_plain(single_kind, '0);
        relex = 1;
      end
    end
    if (relex) begin_token(b, eoi);
    if (lex_mode != stu_pkg::M_HALT && !eoi) begin
      if (b == 8'h0A) begin
        if (cur_line != stu_pkg::POS_MAX) cur_line++;
        cur_col = 16'd1;
      end else if (cur_col != stu_pkg::POS_MAX) cur_col++;
    end
  endtask

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    token_item_t e;
    if (!rst_n) begin
      lex_mode = stu_pkg::M_IDLE;
      digits_acc = '0;
      kept_len = 0;
      quoted_byte = '0;
      cur_line = 16'd1;
      cur_col = 16'd1;
      tok_line = 16'd1;
      tok_col = 16'd1;
      token_items_due.delete();
    end else begin
      if (in_valid && in_ready) lex_transfer(in_byte_req, in_end_of_input);
      if (out_valid && out_ready) begin
        if (token_items_due.size() == 0) begin
          report($sformatf("unexpected item kind %0d", out_kind));
        end else begin
          e = token_items_due.pop_front();
          if (out_kind !== e.kind)
            report($sformatf("kind %0d, want %0d", out_kind, e.kind));
          if (out_error_code !== e.err)
            report($sformatf("error_code %0d, want %0d", out_error_code, e.err));
          if (out_start_line !== e.ln)
            report($sformatf("start_line %0d, want %0d", out_start_line, e.ln));
          if (out_start_column !== e.col)
            report($sformatf("start_column %0d, want %0d", out_start_column, e.col));
          if (out_number !== e.num)
            report($sformatf("number %0d, want %0d", out_number, e.num));
          if (out_text_word !== e.word)
            report($sformatf("text_word %h, want %h", out_text_word, e.word));
          if (out_text_bytes !== e.nbytes)
            report($sformatf("text_bytes %0d, want %0d", out_text_bytes, e.nbytes));
          if (out_last !== e.lst)
            report($sformatf("last %0b, want %0b", out_last, e.lst));
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
// Testbench top: source byte stimulus, receiver stalls, watchdog and verdict.
`timescale 1ns / 1ps
module tb_top;

  // no transfer on either side for this many cycles means the block is stuck
  localparam int STUCK_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [7:0]  in_byte_req = '0;
  logic        in_end_of_input = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [5:0]  out_kind;
  logic [2:0]  out_error_code;
  logic [15:0] out_start_line, out_start_column;
  logic [30:0] out_number;
  logic [63:0] out_text_word;
  logic [3:0]  out_text_bytes;
  logic        out_last, out_valid;
  logic        out_ready = 1'b0;

  int fail_count, outstanding;
  int stuck_cycles = 0;
  int stall_left = 0;
  bit calm = 0;   // set for the closing stretch: no idling at all

  source_tokenizer_unit uut (.*);

  tokenizer_checker chk (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Receiver: stalls in bursts, long clean stretches in between.
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 16);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // One input transfer. Ready is sampled at the falling edge so the driver
  // never races the block at the rising edge that accepts.
  task automatic send(logic [7:0] b, logic eoi = 1'b0);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_byte_req <= b;
    in_end_of_input <= eoi;
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  // end marker; the byte lane carries junk that must be ignored
  task automatic send_eof();
    send(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] pick_alnum();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return 8'($urandom_range("0", "9"));
      default: return "_";
    endcase
  endfunction

  // noise byte: anything that cannot open a literal or a lone & / |
  function automatic logic [7:0] pick_noise();
    logic [7:0] b;
    do b = 8'($urandom); while (b == "\"" || b == "'" || b == "&" || b == "|");
    return b;
  endfunction

  task automatic send_ident(int len);
    send(($urandom_range(0, 1) == 1) ? 8'($urandom_range("a", "z")) : "_");
    for (int i = 1; i < len; i++) send(pick_alnum());
  endtask

  task automatic send_string(int len);
    logic [7:0] b;
    send("\"");
    for (int i = 0; i < len; i++) begin
      do b = 8'($urandom); while (b == "\"");
      send(b);
    end
    send("\"");
  endtask

  task automatic send_gap();
    case ($urandom_range(0, 5))
      0: ;  // abutting tokens exercise the lookahead path
      1: send(8'h0A);
      2: send(8'($urandom_range(9, 13)));
      default: send(" ");
    endcase
  endtask

  // One well-formed token with random content.
  task automatic send_token();
    string kw[13] = '{"int", "bool", "char", "str", "string", "if", "else", "while",
                      "return", "true", "false", "echo", "endl"};
    string ops[22] = '{"+", "-", "*", "/", "(", ")", "{", "}", ";", "!=", "!", "&&",
                       "||", "<", "<=", ">", ">=", "==", "=", "!!", "<<", "=<"};
    int n;
    case ($urandom_range(0, 11))
      0, 1: send_ident(($urandom_range(0, 7) == 0) ? $urandom_range(25, 40)
                                                    : $urandom_range(1, 10));
      2: send_text(kw[$urandom_range(0, 12)]);
      3, 4: begin
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send(8'($urandom_range("0", "9")));
      end
      5, 6: send_text(ops[$urandom_range(0, 21)]);
      7: send_string(($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(0, 12));
      8: begin
        send("'");
        send(8'($urandom));
        send("'");
      end
      9: begin
        send_text("//");
        n = $urandom_range(0, 10);
        for (int i = 0; i < n; i++) send(pick_noise() == 8'h0A ? " " : pick_noise());
        send(8'h0A);
      end
      10: send(pick_noise());
      default: send_eof();
    endcase
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every keyword, operators, limits, literals, unknown bytes.
    send_text("int bool char str string if else while return true false echo endl");
    send_text(" strings\n");
    send_text("0 2147483647 2147483648 12ab\n");
    send_text("+-*/(){};!= !&& ||<<=>>===a/b//n\n");
    send_text("'a' "); send("'"); send(8'hFF); send("'");
    send("'"); send(8'h00); send("'"); send_text("''' \"\" \"hi there\"\n");
    send_string(33);
    send(" ");
    send_ident(33);
    send(8'h80); send(8'hFF); send(8'h00); send("#"); send("@");
    send_eof();
    send_text("x//c");
    send_eof();

    // A few random well-formed tokens with idling on both sides.
    for (int i = 0; i < 4; i++) begin
      send_token();
      send_gap();
    end

    // Closing stretch without idling, then one error that halts the block.
    calm = 1;
    for (int i = 0; i < 4; i++) begin
      send_token();
      send_gap();
    end
    send(" ");
    case ($urandom_range(0, 4))
      0: send_text("'ab");
      1: begin send("'"); send_eof(); end
      2: begin send_text("\"abc"); send_eof(); end
      3: send_text("&x");
      default: begin send("|"); send_eof(); end
    endcase
    send_text("more 1");
    send_eof();
    in_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
